>>> design/fixed_block_free_list_allocator_unit_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBFLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBFLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fbfla_pkg.sv
// Package with constants, codes and types of the block allocator.
`timescale 1ns / 1ps

package fbfla_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int UNITS_W    = 16;
    localparam int ADDR_W     = 48;
    localparam int ALIGN_SH   = 6;              // 64-byte units
    localparam int PROD_W     = IDX_W + UNITS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 64;

    localparam logic [CNT_W-1:0] EMPTY_HEAD = CNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STS_ALLOCATED   = 3'd0,
        STS_EMPTY       = 3'd1,
        STS_FREED       = 3'd2,
        STS_REJECTED    = 3'd3,
        STS_INITIALISED = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_COUNT  = 2'd0,
        REG_BLOCK_UNITS  = 2'd1,
        REG_BASE_ADDRESS = 2'd2
    } cfg_reg_t;

    // Request to the address generator: load the product of index and units.
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] index;
    } addr_req_t;

endpackage

>>> design/fbfla_link_ram.sv
// Generic single-write, single-read synchronous RAM for the free-list links.
`timescale 1ns / 1ps

module fbfla_link_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 11,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/fbfla_addr_gen.sv
// Block address generator: base plus index times units times 64.
`timescale 1ns / 1ps

module fbfla_addr_gen
    import fbfla_pkg::*;
(
    input  logic                aclk,
    input  addr_req_t           req,
    input  logic [UNITS_W-1:0]  block_units,
    input  logic [ADDR_W-1:0]   base_address,
    output logic [ADDR_W-1:0]   address
);

    logic [PROD_W-1:0]            prod_reg;
    logic [PROD_W-1:0]            prod_next;
    logic [PROD_W+ALIGN_SH-1:0]   offset;

    assign prod_next = PROD_W'(req.index) * PROD_W'(block_units);

    always_ff @(posedge aclk) begin
        if (req.load) begin
            prod_reg <= prod_next;
        end
    end

    assign offset  = {prod_reg, ALIGN_SH'(0)};
    assign address = base_address + ADDR_W'(offset);

endmodule

>>> design/fixed_block_free_list_allocator_unit.sv
// Allocate: ST_IDLE accepts, ST_PROD reads a pop's link and loads the product of index
// and size, ST_DONE fills the result register once it is free; other items skip
// ST_PROD. Items are taken only in ST_IDLE, one at a time. The result register lets
// the next item in while a result waits to be taken. Reset: control registers take
// their reset values at once; data registers are not reset; the link memory is not
// cleared (only entries written by a free are ever read), so no clearing pass.
`timescale 1ns / 1ps
`include "fixed_block_free_list_allocator_unit_macros.svh"

module fixed_block_free_list_allocator_unit
    import fbfla_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] operation, [11:2] block_index, [15:12] zero
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] status, [12:3] granted_index, [60:13] granted_address, [63:61] zero
    output logic [M_DATA_W-1:0]   m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PROD = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [UNITS_W-1:0]  units_reg, units_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    untouched_reg, untouched_next;
    logic [IDX_W-1:0]    got_reg, got_next;
    logic                pop_reg, pop_next;
    logic                grant_reg, grant_next;
    status_t             status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [IDX_W-1:0]    m_index_reg, m_index_next;
    logic [ADDR_W-1:0]   m_addr_reg, m_addr_next;

    op_t                 op;
    logic [IDX_W-1:0]    req_idx;
    logic                accept;
    logic                out_free;
    logic [CNT_W-1:0]    eff_count;
    logic [CNT_W-1:0]    untouched_dec;
    logic                ram_we;
    logic                ram_re;
    logic [CNT_W-1:0]    ram_rdata;
    addr_req_t           areq;
    logic [ADDR_W-1:0]   gen_addr;

    assign op       = op_t'(s_axis_tdata[1:0]);
    assign req_idx  = s_axis_tdata[IDX_W+1:2];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign eff_count = (count_reg > EMPTY_HEAD) ? EMPTY_HEAD : count_reg;
    assign untouched_dec = untouched_reg - CNT_W'(1);

    assign areq.load  = (state_reg == ST_PROD);
    assign areq.index = got_reg;

    fbfla_link_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (CNT_W)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (req_idx),
        .wr_data (head_reg),
        .rd_en   (ram_re),
        .rd_addr (head_reg[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    fbfla_addr_gen u_addr_gen (
        .aclk         (aclk),
        .req          (areq),
        .block_units  (units_reg),
        .base_address (base_reg),
        .address      (gen_addr)
    );

    // Configuration writes; the user must issue them only while idle (not enforced here).
    always_comb begin
        count_next = count_reg;
        units_next = units_reg;
        base_next  = base_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_BLOCK_COUNT:  count_next = cfg_wr_data[CNT_W-1:0];
                REG_BLOCK_UNITS:  units_next = cfg_wr_data[UNITS_W-1:0];
                REG_BASE_ADDRESS: base_next  = cfg_wr_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Item sequencer. One item at a time, so a pop's link read never overlaps
    // a push to the same entry.
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        untouched_next = untouched_reg;
        got_next       = got_reg;
        pop_next       = pop_reg;
        grant_next     = grant_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_index_next   = m_index_reg;
        m_addr_next    = m_addr_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    grant_next = 1'b0;
                    pop_next   = 1'b0;
                    state_next = ST_DONE;
                    case (op)
                        OP_ALLOC: begin
                            if (head_reg < EMPTY_HEAD) begin
                                got_next    = head_reg[IDX_W-1:0];
                                pop_next    = 1'b1;
                                ram_re      = 1'b1;
                                grant_next  = 1'b1;
                                status_next = STS_ALLOCATED;
                                state_next  = ST_PROD;
                            end else if (untouched_reg != '0) begin
                                untouched_next = untouched_dec;
                                got_next       = untouched_dec[IDX_W-1:0];
                                grant_next     = 1'b1;
                                status_next    = STS_ALLOCATED;
                                state_next     = ST_PROD;
                            end else begin
                                status_next = STS_EMPTY;
                            end
                        end
                        OP_FREE: begin
                            if ({1'b0, req_idx} < eff_count) begin
                                ram_we      = 1'b1;
                                head_next   = {1'b0, req_idx};
                                status_next = STS_FREED;
                            end else begin
                                status_next = STS_REJECTED;
                            end
                        end
                        OP_INIT: begin
                            head_next      = EMPTY_HEAD;
                            untouched_next = eff_count;
                            status_next    = STS_INITIALISED;
                        end
                        default: begin
                            status_next = STS_REJECTED;
                        end
                    endcase
                end
            end
            ST_PROD: begin
                if (pop_reg) begin
                    head_next = ram_rdata;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_index_next  = grant_reg ? got_reg : '0;
                    m_addr_next   = grant_reg ? gen_addr : '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= EMPTY_HEAD;
            units_reg     <= UNITS_W'(1);
            base_reg      <= '0;
            head_reg      <= EMPTY_HEAD;
            untouched_reg <= EMPTY_HEAD;
            pop_reg       <= 1'b0;
            grant_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            units_reg     <= units_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            untouched_reg <= untouched_next;
            pop_reg       <= pop_next;
            grant_reg     <= grant_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        got_reg      <= got_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_addr_reg   <= m_addr_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_addr_reg, m_index_reg, m_status_reg};

    `FBFLA_ASSERT_NOW(a_head_range, 1'b1, head_reg <= EMPTY_HEAD, "stack head out of range")
    `FBFLA_ASSERT_NOW(a_untouched_range, 1'b1, untouched_reg <= EMPTY_HEAD,
        "untouched count above pool size")
    `FBFLA_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready,
        "new transaction taken while one is in flight")
    `FBFLA_ASSERT_NEXT(a_pop_reads_link, accept && op == OP_ALLOC && head_reg < EMPTY_HEAD,
        state_reg == ST_PROD && pop_reg, "stack pop did not wait for link read")
    `FBFLA_ASSERT_NOW(a_ram_no_overlap, ram_we, !ram_re, "link write and read in one cycle")

endmodule

>>> tb/tb_fixed_block_free_list_allocator_unit.sv
// Testbench for the block allocator: stream stimulus, LIFO free-list predictor, result scoreboard.
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator_unit;
    import fbfla_pkg::*;

    localparam logic [1:0] OP_RESERVED     = 2'd3;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         ITEMS_PER_PHASE = 85;
    localparam int         RANDOM_PHASES   = 10;
    localparam int         IDX_LSB         = 3;
    localparam int         ADDR_LSB        = IDX_LSB + IDX_W;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] address;
    } grant_t;

    // Mirrors the allocator state and holds the grants still owed by the block.
    class alloc_scoreboard;
        logic [CNT_W-1:0]   head;
        logic [CNT_W-1:0]   untouched;
        logic [CNT_W-1:0]   link_mem [MAX_BLOCKS];
        logic [CNT_W-1:0]   count_reg;
        logic [UNITS_W-1:0] units_reg;
        logic [ADDR_W-1:0]  base_reg;
        grant_t             grant_q [$];
        int                 errors;

        function new();
            count_reg = CNT_W'(MAX_BLOCKS);
            units_reg = UNITS_W'(1);
            base_reg  = '0;
            head      = EMPTY_HEAD;
            untouched = CNT_W'(MAX_BLOCKS);
            foreach (link_mem[i]) link_mem[i] = '0;
            errors    = 0;
        endfunction

        // Count register saturated to the pool capacity.
        function logic [CNT_W-1:0] usable_blocks();
            return (count_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_reg;
        endfunction

        function void write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
            case (sel)
                REG_BLOCK_COUNT:  count_reg = value[CNT_W-1:0];
                REG_BLOCK_UNITS:  units_reg = value[UNITS_W-1:0];
                REG_BASE_ADDRESS: base_reg  = value[ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        function grant_t note_request(logic [1:0] op, logic [IDX_W-1:0] idx);
            grant_t            grant;
            logic [CNT_W-1:0]  got;
            logic [ADDR_W-1:0] offset;
            grant        = '0;
            grant.status = STS_REJECTED;
            got          = '0;
            case (op)
                OP_ALLOC: begin
                    grant.status = STS_ALLOCATED;
                    if (head < EMPTY_HEAD) begin
                        got  = head;
                        head = link_mem[head[IDX_W-1:0]];
                    end else if (untouched != '0) begin
                        // untouched blocks go out highest index first
                        untouched = untouched - 1'b1;
                        got       = untouched;
                    end else begin
                        grant.status = STS_EMPTY;
                    end
                    if (grant.status == STS_ALLOCATED) begin
                        offset        = ADDR_W'(got[IDX_W-1:0]) * ADDR_W'(units_reg);
                        grant.index   = got[IDX_W-1:0];
                        grant.address = base_reg + (offset << ALIGN_SH);
                    end
                end
                OP_FREE: begin
                    // range check uses the live register, not the count at init
                    if (CNT_W'(idx) < usable_blocks()) begin
                        link_mem[idx] = head;
                        head          = CNT_W'(idx);
                        grant.status  = STS_FREED;
                    end
                end
                OP_INIT: begin
                    head         = EMPTY_HEAD;
                    untouched    = usable_blocks();
                    grant.status = STS_INITIALISED;
                end
                default: ;
            endcase
            grant_q.push_back(grant);
            return grant;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            grant_t grant;
            if (grant_q.size() == 0) begin
                $error("unexpected result transaction, tdata %h", data);
                errors++;
            end else begin
                grant = grant_q.pop_front();
                if (data[2:0] !== grant.status) begin
                    $error("status: expected %0d, actual %0d", grant.status, data[2:0]);
                    errors++;
                end
                if (data[IDX_LSB +: IDX_W] !== grant.index) begin
                    $error("granted_index: expected %0d, actual %0d",
                           grant.index, data[IDX_LSB +: IDX_W]);
                    errors++;
                end
                if (data[ADDR_LSB +: ADDR_W] !== grant.address) begin
                    $error("granted_address: expected %h, actual %h",
                           grant.address, data[ADDR_LSB +: ADDR_W]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    alloc_scoreboard sb;
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    int              hold_req    = 0;
    int              hold_left   = 0;
    int              cycle_count = 0;
    int              held_q [$];

    fixed_block_free_list_allocator_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check each transaction, then pick tready for the next edge.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        grant_t grant;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - IDX_W - 2){1'b0}}, idx, op};
        do @(posedge aclk); while (!s_axis_tready);
        grant = sb.note_request(op, idx);
        if (op == OP_ALLOC && grant.status == STS_ALLOCATED) begin
            held_q.push_back(grant.index);
        end else if (op == OP_INIT) begin
            held_q.delete();
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.grant_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= sel;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.write_reg(sel, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly allocs and frees of granted blocks; the rest hits range edges and noise.
    task automatic send_random_item();
        int               sel;
        int               pick;
        int               usable;
        logic [IDX_W-1:0] idx;
        sel    = $urandom_range(99);
        usable = sb.usable_blocks();
        idx    = IDX_W'($urandom);
        if (sel < 45 || (sel < 75 && held_q.size() == 0)) begin
            send_item(OP_ALLOC, idx);
        end else if (sel < 75) begin
            pick = $urandom_range(held_q.size() - 1);
            idx  = IDX_W'(held_q[pick]);
            held_q.delete(pick);
            send_item(OP_FREE, idx);
        end else if (sel < 85) begin
            send_item(OP_FREE, idx);
        end else if (sel < 90 && usable > 0) begin
            // may repeat a free or push a block that was never handed out
            send_item(OP_FREE, IDX_W'($urandom_range(usable - 1)));
        end else if (sel < 95) begin
            send_item(OP_FREE, IDX_W'(usable - 1 + $urandom_range(2)));
        end else if (sel < 97) begin
            send_item(OP_INIT, idx);
        end else begin
            send_item(OP_RESERVED, idx);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] count_val;
        logic [CFG_DATA_W-1:0] units_val;
        logic [CFG_DATA_W-1:0] base_val;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: 1024 blocks of 64 bytes at address zero
        rx_idle_pct = 68;
        send_item(OP_ALLOC, {IDX_W{1'b1}});
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, IDX_W'(1023));
        send_item(OP_FREE, IDX_W'(1023));
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_RESERVED, {IDX_W{1'b1}});
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);

        // shrink the count without init; widest block size; addresses wrap
        wait_drain();
        write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(2));
        write_reg(REG_BLOCK_UNITS, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_BASE_ADDRESS, 48'hFFFF_FFFF_FFC0);
        send_item(OP_FREE, IDX_W'(1));
        send_item(OP_FREE, IDX_W'(2));
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, IDX_W'(1023));

        // empty pool, zero block size
        wait_drain();
        write_reg(REG_BLOCK_COUNT, '0);
        write_reg(REG_BLOCK_UNITS, '0);
        send_item(OP_INIT, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, '0);

        // count above capacity saturates
        wait_drain();
        write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(2047));
        send_item(OP_INIT, '0);
        send_item(OP_FREE, IDX_W'(1023));
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drain();
            if (p == 0) begin
                tx_idle_pct = 18;
                rx_idle_pct = 68;
            end else if (p == 4) begin
                tx_idle_pct = 68;
                rx_idle_pct = 18;
            end else if (p == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0:       count_val = CFG_DATA_W'(1024);
                1:       count_val = CFG_DATA_W'(1);
                2:       count_val = CFG_DATA_W'(7);
                3:       count_val = CFG_DATA_W'(3);
                4:       count_val = CFG_DATA_W'(40);
                5:       count_val = CFG_DATA_W'(2047);
                6:       count_val = CFG_DATA_W'(12);
                7:       count_val = '0;
                8:       count_val = CFG_DATA_W'(2);
                default: count_val = CFG_DATA_W'(20);
            endcase
            if (p == 1) begin
                units_val = '0;
            end else if (p == 5) begin
                units_val = CFG_DATA_W'(16'hFFFF);
            end else if ($urandom_range(1) == 0) begin
                units_val = CFG_DATA_W'($urandom_range(8, 1));
            end else begin
                units_val = CFG_DATA_W'($urandom_range(65535, 1));
            end
            if (p == 3) begin
                base_val = {CFG_DATA_W{1'b1}};
            end else if (p == 8) begin
                base_val = '0;
            end else begin
                base_val = CFG_DATA_W'({$urandom, $urandom});
            end
            write_reg(REG_BLOCK_COUNT, count_val);
            write_reg(REG_BLOCK_UNITS, units_val);
            write_reg(REG_BASE_ADDRESS, base_val);
            send_item(OP_INIT, IDX_W'($urandom));
            // long receiver stall so the pipeline backs up into the input
            if (p == 2) hold_req = 300;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 5 && n == ITEMS_PER_PHASE / 2) wait_drain();
                send_random_item();
            end
        end

        wait_drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
